FILE: hdl/pht_pkg.sv
// ----------------------------------------------------------------------------
// pht_pkg
// Shared types and widths for the path horizon truncation block.
// ----------------------------------------------------------------------------
package pht_pkg;

   localparam int COORD_FRAC_BITS = 16;
   localparam int RADIUS_W        = 31;
   localparam int RAD_W           = 72;
   localparam int ROOT_W          = RAD_W / 2;
   localparam int DIV_W           = 72;
   localparam int DEN_W           = 35;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic               path_end;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               is_cut_point;
      logic               final_point;
   } rsp_type;

   typedef struct packed {
      logic             cut;
      logic             fin;
      logic [2:0][31:0] pt;
      logic [2:0][31:0] prev;
      logic [2:0][31:0] orig;
   } job_type;

   typedef struct packed {
      logic push;
      logic full;
   } qctl_type;

endpackage

FILE: hdl/pht_front.sv
// ----------------------------------------------------------------------------
// pht_front
// Accepts path points, tracks origin and previous point, classifies each
// beat as pass, cut (by squared distance) or drop, and queues pass and cut jobs.
// ----------------------------------------------------------------------------
module pht_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pht_pkg::req_type                  req_data,
   input  logic [pht_pkg::RADIUS_W-1:0]      horizon_radius,
   input  logic                              q_full,
   output logic                              q_push,
   output pht_pkg::job_type                  q_job
);

   typedef enum logic [1:0] {F_IDLE, F_SQ, F_PUSH} state_type;

   state_type        state_ff;
   pht_pkg::req_type in_ff;
   logic [1:0]       k_ff;
   logic [66:0]      acc_ff;
   logic [61:0]      r2_ff;
   logic [2:0][31:0] orig_ff;
   logic [2:0][31:0] prev_ff;
   logic             seen_ff;
   logic             cut_done_ff;

   logic [2:0][31:0]   pt;
   logic signed [32:0] op;
   logic signed [65:0] sq;
   logic               near;
   logic               drop;
   logic               go;

   assign pt[0] = in_ff.point_x;
   assign pt[1] = in_ff.point_y;
   assign pt[2] = in_ff.point_z;

   always_comb begin
      case (k_ff)
         2'd0:    op = $signed({pt[0][31], pt[0]}) - $signed({orig_ff[0][31], orig_ff[0]});
         2'd1:    op = $signed({pt[1][31], pt[1]}) - $signed({orig_ff[1][31], orig_ff[1]});
         2'd2:    op = $signed({pt[2][31], pt[2]}) - $signed({orig_ff[2][31], orig_ff[2]});
         default: op = $signed({2'b00, horizon_radius});
      endcase
   end

   assign sq        = op * op;
   assign near      = acc_ff < {5'd0, r2_ff};
   assign drop      = seen_ff && cut_done_ff;
   assign go        = (state_ff == F_PUSH) && (drop || !q_full);
   assign req_ready = (state_ff == F_IDLE);
   assign q_push    = go && !drop;

   always_comb begin
      q_job.cut  = seen_ff && !near;
      q_job.fin  = in_ff.path_end || (seen_ff && !near);
      q_job.pt   = pt;
      q_job.prev = prev_ff;
      q_job.orig = orig_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         k_ff        <= 2'd0;
         seen_ff     <= 1'b0;
         cut_done_ff <= 1'b0;
         orig_ff     <= '0;
         prev_ff     <= '0;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  in_ff    <= req_data;
                  k_ff     <= 2'd0;
                  acc_ff   <= '0;
                  state_ff <= F_SQ;
               end
            end
            F_SQ: begin
               if (k_ff == 2'd3) begin
                  r2_ff    <= sq[61:0];
                  state_ff <= F_PUSH;
               end else begin
                  acc_ff <= acc_ff + {2'd0, sq[64:0]};
               end
               k_ff <= k_ff + 2'd1;
            end
            F_PUSH: begin
               if (go) begin
                  state_ff <= F_IDLE;
                  if (in_ff.path_end) begin
                     seen_ff     <= 1'b0;
                     cut_done_ff <= 1'b0;
                     orig_ff     <= '0;
                     prev_ff     <= '0;
                  end else if (!seen_ff) begin
                     seen_ff <= 1'b1;
                     orig_ff <= pt;
                     prev_ff <= pt;
                  end else if (!cut_done_ff) begin
                     if (near) begin
                        prev_ff <= pt;
                     end else begin
                        cut_done_ff <= 1'b1;
                     end
                  end
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

FILE: hdl/pht_fifo.sv
// ----------------------------------------------------------------------------
// pht_fifo
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module pht_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pht_pkg::job_type wr_job,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output pht_pkg::job_type rd_job
);

   pht_pkg::job_type mem_ff [2];
   logic             wr_ff;
   logic             rd_ff;
   logic [1:0]       cnt_ff;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign rd_job    = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

FILE: hdl/pht_sqrt.sv
// ----------------------------------------------------------------------------
// pht_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pht_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pht_pkg::RAD_W-1:0]     radicand,
   output logic                          done,
   output logic [pht_pkg::ROOT_W-1:0]    root
);

   localparam int RW = pht_pkg::ROOT_W;
   localparam int NW = pht_pkg::RAD_W;

   logic [NW-1:0] num_ff;
   logic [RW+1:0] rem_ff;
   logic [RW-1:0] root_ff;
   logic [5:0]    cnt_ff;
   logic          busy_ff;
   logic          done_ff;

   logic [RW+1:0] rem_sh;
   logic [RW+1:0] trial;
   logic          take;

   assign rem_sh = {rem_ff[RW-1:0], num_ff[NW-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign take   = rem_sh >= trial;
   assign done   = done_ff;
   assign root   = root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == 6'(RW - 1));
         if (start) begin
            num_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            num_ff  <= {num_ff[NW-3:0], 2'b00};
            rem_ff  <= take ? rem_sh - trial : rem_sh;
            root_ff <= {root_ff[RW-2:0], take};
            cnt_ff  <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(RW - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

endmodule

FILE: hdl/pht_div.sv
// ----------------------------------------------------------------------------
// pht_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pht_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pht_pkg::DIV_W-1:0]    dividend,
   input  logic [pht_pkg::DEN_W-1:0]    divisor,
   output logic                         done,
   output logic [pht_pkg::DIV_W-1:0]    quotient
);

   localparam int QW = pht_pkg::DIV_W;
   localparam int DW = pht_pkg::DEN_W;

   logic [QW-1:0] num_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] den_ff;
   logic [6:0]    cnt_ff;
   logic          busy_ff;
   logic          done_ff;

   logic [DW:0] rem_sh;
   logic        take;

   assign rem_sh   = {rem_ff, num_ff[QW-1]};
   assign take     = rem_sh >= {1'b0, den_ff};
   assign done     = done_ff;
   assign quotient = num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == 7'(QW - 1));
         if (start) begin
            num_ff  <= dividend;
            den_ff  <= divisor;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff  <= take ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
            num_ff  <= {num_ff[QW-2:0], take};
            cnt_ff  <= cnt_ff + 7'd1;
            if (cnt_ff == 7'(QW - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

endmodule

FILE: hdl/pht_back.sv
// ----------------------------------------------------------------------------
// pht_back
// Executes queued jobs: passes points straight to the output register, or
// computes the horizon crossing with a shared multiplier, root and divider.
// ----------------------------------------------------------------------------
module pht_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pht_pkg::RADIUS_W-1:0]  horizon_radius,
   input  logic                          q_valid,
   input  pht_pkg::job_type              q_job,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output pht_pkg::rsp_type              rsp_data
);

   typedef enum logic [3:0] {
      B_IDLE, B_MAC, B_SQL, B_DIVP, B_DISC, B_SQD, B_MULO, B_DIVO, B_OUT
   } state_type;

   state_type          state_ff;
   pht_pkg::job_type   job_ff;
   logic [3:0]         k_ff;
   logic signed [67:0] l2_ff;
   logic signed [67:0] dot_ff;
   logic signed [67:0] w2_ff;
   logic [pht_pkg::DEN_W-1:0] len_ff;
   logic signed [39:0] proj_ff;
   logic signed [75:0] disc_ff;
   logic [37:0]        t_ff;
   logic [2:0][31:0]   res_ff;
   logic               sq_go_ff;
   logic [pht_pkg::RAD_W-1:0] sq_in_ff;
   logic               dv_go_ff;
   logic [pht_pkg::DIV_W-1:0] dv_in_ff;
   logic               rsp_valid_ff;
   pht_pkg::rsp_type   rsp_ff;

   logic signed [32:0] u [3];
   logic signed [32:0] w [3];
   logic signed [38:0] mul_a;
   logic signed [38:0] mul_b;
   logic signed [77:0] mul_p;
   logic               out_free;
   logic               sq_done;
   logic [pht_pkg::ROOT_W-1:0] sq_root;
   logic               dv_done;
   logic [pht_pkg::DIV_W-1:0] dv_q;
   logic [67:0]        dot_mag;
   logic signed [75:0] disc_sum;
   logic signed [40:0] t_sum;
   logic [1:0]         kc;
   logic signed [73:0] crd;
   logic signed [31:0] crd_sat;
   logic               sq_go_in;
   logic               dv_go_in;
   logic               rsp_valid_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u[i] = $signed({job_ff.pt[i][31], job_ff.pt[i]})
              - $signed({job_ff.prev[i][31], job_ff.prev[i]});
         w[i] = $signed({job_ff.orig[i][31], job_ff.orig[i]})
              - $signed({job_ff.prev[i][31], job_ff.prev[i]});
      end
   end

   assign kc = k_ff[1:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         B_MAC: begin
            case (k_ff)
               4'd0: begin mul_a = 39'(u[0]); mul_b = 39'(u[0]); end
               4'd1: begin mul_a = 39'(u[1]); mul_b = 39'(u[1]); end
               4'd2: begin mul_a = 39'(u[2]); mul_b = 39'(u[2]); end
               4'd3: begin mul_a = 39'(w[0]); mul_b = 39'(u[0]); end
               4'd4: begin mul_a = 39'(w[1]); mul_b = 39'(u[1]); end
               4'd5: begin mul_a = 39'(w[2]); mul_b = 39'(u[2]); end
               4'd6: begin mul_a = 39'(w[0]); mul_b = 39'(w[0]); end
               4'd7: begin mul_a = 39'(w[1]); mul_b = 39'(w[1]); end
               default: begin mul_a = 39'(w[2]); mul_b = 39'(w[2]); end
            endcase
         end
         B_DISC: begin
            if (k_ff == 4'd0) begin
               mul_a = 39'(proj_ff);
               mul_b = 39'(proj_ff);
            end else begin
               mul_a = $signed({8'd0, horizon_radius});
               mul_b = $signed({8'd0, horizon_radius});
            end
         end
         B_MULO: begin
            mul_a = $signed({1'b0, t_ff});
            case (kc)
               2'd0:    mul_b = u[0][32] ? 39'(-u[0]) : 39'(u[0]);
               2'd1:    mul_b = u[1][32] ? 39'(-u[1]) : 39'(u[1]);
               default: mul_b = u[2][32] ? 39'(-u[2]) : 39'(u[2]);
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign dot_mag  = dot_ff[67] ? 68'(-dot_ff) : 68'(dot_ff);
   assign disc_sum = disc_ff + 76'(mul_p) - 76'(w2_ff);
   assign t_sum    = 41'(proj_ff) + $signed({5'd0, sq_root});

   always_comb begin
      case (kc)
         2'd0:    crd = $signed({{42{job_ff.prev[0][31]}}, job_ff.prev[0]});
         2'd1:    crd = $signed({{42{job_ff.prev[1][31]}}, job_ff.prev[1]});
         default: crd = $signed({{42{job_ff.prev[2][31]}}, job_ff.prev[2]});
      endcase
      if (u[kc][32]) begin
         crd = crd - $signed({2'b00, dv_q});
      end else begin
         crd = crd + $signed({2'b00, dv_q});
      end
      if (crd > 74'sd2147483647) begin
         crd_sat = 32'sh7fffffff;
      end else if (crd < -74'sd2147483648) begin
         crd_sat = 32'sh80000000;
      end else begin
         crd_sat = crd[31:0];
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign q_pop     = (state_ff == B_IDLE) && q_valid && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign sq_go_in     = ((state_ff == B_MAC) && (k_ff == 4'd8) && (l2_ff != '0))
                      || ((state_ff == B_DISC) && (k_ff != 4'd0));
   assign dv_go_in     = ((state_ff == B_SQL) && sq_done) || (state_ff == B_MULO);
   assign rsp_valid_in = (q_pop && !q_job.cut) || ((state_ff == B_OUT) && out_free)
                      || (rsp_valid_ff && !rsp_ready);

   pht_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_go_ff),
      .radicand (sq_in_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   pht_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_go_ff),
      .dividend (dv_in_ff),
      .divisor  (len_ff),
      .done     (dv_done),
      .quotient (dv_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         k_ff         <= '0;
         sq_go_ff     <= 1'b0;
         dv_go_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sq_go_ff     <= sq_go_in;
         dv_go_ff     <= dv_go_in;
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            B_IDLE: begin
               if (q_pop) begin
                  job_ff <= q_job;
                  if (q_job.cut) begin
                     k_ff     <= '0;
                     l2_ff    <= '0;
                     dot_ff   <= '0;
                     w2_ff    <= '0;
                     state_ff <= B_MAC;
                  end else begin
                     rsp_ff.out_x        <= q_job.pt[0];
                     rsp_ff.out_y        <= q_job.pt[1];
                     rsp_ff.out_z        <= q_job.pt[2];
                     rsp_ff.is_cut_point <= 1'b0;
                     rsp_ff.final_point  <= q_job.fin;
                  end
               end
            end
            B_MAC: begin
               if (k_ff < 4'd3) begin
                  l2_ff <= l2_ff + mul_p[67:0];
               end else if (k_ff < 4'd6) begin
                  dot_ff <= dot_ff + mul_p[67:0];
               end else begin
                  w2_ff <= w2_ff + mul_p[67:0];
               end
               k_ff <= k_ff + 4'd1;
               if (k_ff == 4'd8) begin
                  if (l2_ff == '0) begin
                     res_ff   <= job_ff.prev;
                     state_ff <= B_OUT;
                  end else begin
                     sq_in_ff <= {4'd0, l2_ff};
                     state_ff <= B_SQL;
                  end
               end
            end
            B_SQL: begin
               if (sq_done) begin
                  len_ff   <= sq_root[pht_pkg::DEN_W-1:0];
                  dv_in_ff <= {4'd0, dot_mag};
                  state_ff <= B_DIVP;
               end
            end
            B_DIVP: begin
               if (dv_done) begin
                  proj_ff  <= dot_ff[67] ? -$signed(dv_q[39:0]) : $signed(dv_q[39:0]);
                  k_ff     <= '0;
                  state_ff <= B_DISC;
               end
            end
            B_DISC: begin
               if (k_ff == 4'd0) begin
                  disc_ff <= 76'(mul_p);
                  k_ff    <= 4'd1;
               end else begin
                  sq_in_ff <= disc_sum[75] ? '0 : disc_sum[pht_pkg::RAD_W-1:0];
                  state_ff <= B_SQD;
               end
            end
            B_SQD: begin
               if (sq_done) begin
                  t_ff     <= t_sum[40] ? '0 : t_sum[37:0];
                  k_ff     <= '0;
                  state_ff <= B_MULO;
               end
            end
            B_MULO: begin
               dv_in_ff <= mul_p[pht_pkg::DIV_W-1:0];
               state_ff <= B_DIVO;
            end
            B_DIVO: begin
               if (dv_done) begin
                  res_ff[kc] <= crd_sat;
                  k_ff       <= k_ff + 4'd1;
                  state_ff   <= (kc == 2'd2) ? B_OUT : B_MULO;
               end
            end
            B_OUT: begin
               if (out_free) begin
                  rsp_ff.out_x        <= res_ff[0];
                  rsp_ff.out_y        <= res_ff[1];
                  rsp_ff.out_z        <= res_ff[2];
                  rsp_ff.is_cut_point <= 1'b1;
                  rsp_ff.final_point  <= job_ff.fin;
                  state_ff            <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

FILE: hdl/path_horizon_truncation_top.sv
// ----------------------------------------------------------------------------
// path_horizon_truncation_top
// Truncates a stream of 3D path points at a horizon radius from the origin.
// ----------------------------------------------------------------------------
// Input beats on req_* carry one Q15.16 point and a path_end flag; result
// beats on rsp_* carry the passed or crossing point with cut and final flags.
// csr_we/csr_wdata write the horizon radius; write it only while idle.
// The first point of a path is the origin. Later points pass while strictly
// inside the radius; the first one at or beyond it yields the crossing point,
// marked cut and final, and the rest of the path yields no beat.
// Front end: accept, four squaring steps on one multiplier, classify and push
// into a 2-deep job queue; it takes no new point until the push, which waits
// while the queue is full. Passed points are popped by the idle back end
// straight into the output register that drives rsp_valid.
// Crossing: in the back end, nine multiply-accumulate steps, two 36-step
// roots and four 72-step divides on shared units.
// Stalls on rsp_ready fill the output register and queue, then hold req_ready
// low; nothing is lost. Synchronous reset clears the path state, the queue
// and the radius (zero); the block takes a beat in the cycle after reset.
// ----------------------------------------------------------------------------
module path_horizon_truncation_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pht_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pht_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [pht_pkg::RADIUS_W-1:0]      csr_wdata
);

   logic [pht_pkg::RADIUS_W-1:0] radius_ff;
   pht_pkg::qctl_type            qctl;
   pht_pkg::job_type             push_job;
   pht_pkg::job_type             pop_job;
   logic                         q_pop;
   logic                         q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else if (csr_we) begin
         radius_ff <= csr_wdata;
      end
   end

   pht_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .horizon_radius (radius_ff),
      .q_full         (qctl.full),
      .q_push         (qctl.push),
      .q_job          (push_job)
   );

   pht_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (qctl.push),
      .wr_job    (push_job),
      .full      (qctl.full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .rd_job    (pop_job)
   );

   pht_back u_back (
      .clock          (clock),
      .reset          (reset),
      .horizon_radius (radius_ff),
      .q_valid        (q_valid),
      .q_job          (pop_job),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

`ifndef SYNTHESIS
   a_cut_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_cut_point |-> rsp_data.final_point)
      else $error("cut beat not marked final");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      qctl.full |-> !qctl.push)
      else $error("job queue overflow");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("front end took a second beat while busy");
`endif

endmodule

FILE: verif/path_horizon_truncation_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_horizon_truncation_top_tb
// Self-checking bench for the path horizon truncation block.
// ----------------------------------------------------------------------------
// Drives point beats on req_*, predicts every passed or crossing point with a
// wide-integer model of the truncation and compares each rsp_* beat against
// the oldest prediction. Directed paths cover single points, cuts, dropped
// tails, zero and full radius and extreme coordinates; random paths follow,
// under three idling patterns and several radius settings.
// ----------------------------------------------------------------------------
module path_horizon_truncation_top_tb;

   typedef logic signed [127:0] wide_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   pht_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   pht_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic [pht_pkg::RADIUS_W-1:0] csr_wdata = '0;

   pht_pkg::rsp_type expected_points[$];
   int unsigned      errors = 0;
   int unsigned      points_sent = 0;
   int unsigned      points_seen = 0;
   int unsigned      cuts_seen = 0;
   int unsigned      quiet_cycles = 0;
   int unsigned      send_idle = 0;
   int unsigned      recv_idle = 0;

   // predictor path state
   logic signed [63:0] org_pt[3];
   logic signed [63:0] prv_pt[3];
   bit               origin_seen = 0;
   bit               cut_done = 0;
   logic [pht_pkg::RADIUS_W-1:0] radius_m = '0;

   path_horizon_truncation_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   function automatic logic [127:0] root_floor(input logic [127:0] n);
      logic [127:0] res;
      logic [127:0] cand;
      res = '0;
      for (int b = 39; b >= 0; b--) begin
         cand = res | (128'd1 << b);
         if (!(n < cand * cand)) res = cand;
      end
      return res;
   endfunction

   function automatic logic signed [63:0] sat_s32(input wide_type v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v[63:0];
   endfunction

   function automatic void clear_path();
      for (int i = 0; i < 3; i++) begin
         org_pt[i] = '0;
         prv_pt[i] = '0;
      end
      origin_seen = 0;
      cut_done = 0;
   endfunction

   task automatic horizon_predict(input pht_pkg::req_type r);
      logic signed [63:0] p[3];
      logic signed [63:0] q[3];
      wide_type d, d2, rr, u[3], w[3], l2, dot, w2, len, proj, disc, t, off;
      bit cut;
      pht_pkg::rsp_type o;
      p[0] = r.point_x; p[1] = r.point_y; p[2] = r.point_z;
      cut = 0;
      rr = wide_type'({97'd0, radius_m});
      if (!origin_seen) begin
         for (int i = 0; i < 3; i++) begin
            org_pt[i] = p[i]; prv_pt[i] = p[i]; q[i] = p[i];
         end
         origin_seen = 1;
      end else if (cut_done) begin
         if (r.path_end) clear_path();
         return;
      end else begin
         d2 = 0;
         for (int i = 0; i < 3; i++) begin
            d = wide_type'(p[i]) - wide_type'(org_pt[i]);
            d2 += d * d;
         end
         if (d2 < rr * rr) begin
            for (int i = 0; i < 3; i++) begin
               prv_pt[i] = p[i]; q[i] = p[i];
            end
         end else begin
            l2 = 0; dot = 0; w2 = 0;
            for (int i = 0; i < 3; i++) begin
               u[i] = wide_type'(p[i]) - wide_type'(prv_pt[i]);
               w[i] = wide_type'(org_pt[i]) - wide_type'(prv_pt[i]);
               l2 += u[i] * u[i];
               dot += w[i] * u[i];
               w2 += w[i] * w[i];
            end
            len = root_floor(l2);
            if (len == 0) begin
               for (int i = 0; i < 3; i++) q[i] = prv_pt[i];
            end else begin
               proj = (dot < 0) ? -((-dot) / len) : dot / len;
               disc = proj * proj + rr * rr - w2;
               if (disc < 0) disc = 0;
               t = proj + wide_type'(root_floor(disc));
               if (t < 0) t = 0;
               for (int i = 0; i < 3; i++) begin
                  off = (t * ((u[i] < 0) ? -u[i] : u[i])) / len;
                  q[i] = sat_s32(wide_type'(prv_pt[i]) + ((u[i] < 0) ? -off : off));
               end
            end
            cut = 1;
            cut_done = 1;
         end
      end
      o.out_x = q[0][31:0];
      o.out_y = q[1][31:0];
      o.out_z = q[2][31:0];
      o.is_cut_point = cut;
      o.final_point = cut | r.path_end;
      expected_points.insert(expected_points.size(), o);
      if (r.path_end) clear_path();
   endtask

   // accepted beats are sampled on the falling edge ahead of the accepting edge
   always @(negedge clock) begin
      if (!reset) begin
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= 20000) begin
            $display("path_horizon_truncation_top verification failed");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            points_seen++;
            if (rsp_data.is_cut_point) cuts_seen++;
            if (expected_points.size() == 0) begin
               $error("unexpected result beat %p", rsp_data);
               errors++;
            end else begin
               pht_pkg::rsp_type e;
               e = expected_points.pop_front();
               if (rsp_data.out_x !== e.out_x) begin
                  $error("out_x expected %0d actual %0d", e.out_x, rsp_data.out_x); errors++;
               end
               if (rsp_data.out_y !== e.out_y) begin
                  $error("out_y expected %0d actual %0d", e.out_y, rsp_data.out_y); errors++;
               end
               if (rsp_data.out_z !== e.out_z) begin
                  $error("out_z expected %0d actual %0d", e.out_z, rsp_data.out_z); errors++;
               end
               if (rsp_data.is_cut_point !== e.is_cut_point) begin
                  $error("is_cut_point expected %0b actual %0b",
                         e.is_cut_point, rsp_data.is_cut_point);
                  errors++;
               end
               if (rsp_data.final_point !== e.final_point) begin
                  $error("final_point expected %0b actual %0b",
                         e.final_point, rsp_data.final_point);
                  errors++;
               end
            end
         end
      end
   end

   task automatic send_point(input int x, input int y, input int z, input bit last);
      pht_pkg::req_type item;
      item.point_x = x; item.point_y = y; item.point_z = z; item.path_end = last;
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      horizon_predict(item);
      points_sent++;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_radius(input logic [pht_pkg::RADIUS_W-1:0] r);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= r;
      @(posedge clock);
      csr_we <= 1'b0;
      radius_m = r;
   endtask

   function automatic int clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return int'(v);
   endfunction

   function automatic longint rnd_off(input longint span);
      return longint'($urandom_range(32'(2 * span))) - span;
   endfunction

   task automatic test_directed();
      set_radius(31'd10 << 16);
      send_point(32'sd5 << 16, 0, 0, 1);
      send_point(0, 0, 0, 0);
      send_point(32'sd3 << 16, 32'sd4 << 16, 0, 0);
      send_point(32'sd20 << 16, 0, -(32'sd7 << 16), 0);
      send_point(1, 2, 3, 0);
      send_point(-5, 6, 7, 1);
      send_point(0, 0, 0, 0);
      send_point(32'sd10 << 16, 0, 0, 1);
      set_radius('0);
      send_point(32'sd100, -32'sd100, 32'sd7, 0);
      send_point(32'sd100, -32'sd100, 32'sd7, 1);
      send_point(0, 0, 0, 0);
      send_point(32'sd9, 0, 0, 1);
      set_radius(31'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_point(0, 0, 0, 1);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1);
   endtask

   task automatic test_random_paths(input int n_items, input bit hold_mid);
      int sent;
      int plen;
      longint scale;
      longint cur[3];
      sent = 0;
      while (sent < n_items) begin
         if (hold_mid && sent >= n_items / 2 && sent < n_items / 2 + 8) begin
            wait_idle();
            hold_mid = 0;
         end
         plen = $urandom_range(1, 8);
         scale = (radius_m == 0) ? 64'd65536 : longint'(radius_m) / 3 + 1;
         if (scale > 64'd500_000_000) scale = 64'd500_000_000;
         for (int i = 0; i < 3; i++) cur[i] = longint'(int'($urandom()));
         for (int k = 0; k < plen; k++) begin
            if ($urandom_range(9) == 0) begin
               send_point(int'($urandom()), int'($urandom()), int'($urandom()),
                          $urandom_range(7) == 0);
            end else begin
               send_point(clamp32(cur[0]), clamp32(cur[1]), clamp32(cur[2]), k == plen - 1);
            end
            for (int i = 0; i < 3; i++) cur[i] = clamp32(cur[i] + rnd_off(scale));
            sent++;
         end
      end
   endtask

   task automatic test_phase(input int unsigned s_idle, input int unsigned r_idle);
      send_idle = s_idle;
      recv_idle = r_idle;
      set_radius(31'($urandom_range(32'h0001_0000, 32'h0100_0000)));
      test_random_paths(200, 1);
      set_radius('0);
      test_random_paths(100, 0);
      set_radius(31'h7FFF_FFFF);
      test_random_paths(150, 0);
      set_radius(31'($urandom()));
      test_random_paths(150, 0);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      clear_path();
      test_directed();
      test_phase(24, 58);
      test_phase(58, 24);
      test_phase(0, 0);
      wait_idle();
      $display("Sent %0d points over directed and random paths; %0d result beats, %0d cuts.",
               points_sent, points_seen, cuts_seen);
      if (errors == 0 && expected_points.size() == 0) begin
         $display("path_horizon_truncation_top verification clean");
      end else begin
         $display("path_horizon_truncation_top verification failed");
      end
      $finish;
   end

endmodule
